// File: src/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg: shared types for the first-fit heap allocator core.
// Holds the command and result word types, the microcode field codes and the
// control store that sequences the allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffha_pkg;

  // Default heap size in bytes and the fixed geometry of a heap word.
  localparam int HEAP_BYTES_DEF = 1024;
  localparam int WORD_BYTES     = 8;
  localparam int ALIGN_BYTES    = 16;
  localparam int SIZE_W         = 11;
  localparam int INDEX_W        = 7;

  // Operation codes carried in the command word.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Command word.
  typedef struct packed {
    logic               opcode;
    logic [SIZE_W-1:0]  size_bytes;
    logic [INDEX_W-1:0] payload_index;
  } cmd_t;

  // Result word.
  typedef struct packed {
    logic               ok;
    logic [INDEX_W-1:0] result_index;
  } result_t;

  // Microprogram step addresses.
  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DISPATCH,
    S_A_RD,
    S_A_WAIT,
    S_A_HIT,
    S_A_TAKE,
    S_A_SPLIT,
    S_A_WREST,
    S_A_WHDR,
    S_F_CHK,
    S_F_WAIT,
    S_F_CLR,
    S_FAIL
  } step_t;

  // Header memory operation.
  typedef enum logic [1:0] {
    M_NONE,
    M_RD,
    M_WR
  } mem_op_t;

  // Header memory address source.
  typedef enum logic [1:0] {
    A_ZERO,
    A_HDR,
    A_SPLIT,
    A_FREE
  } addr_sel_t;

  // Header memory write data source.
  typedef enum logic [2:0] {
    W_INIT,
    W_TAKE,
    W_RND,
    W_REST,
    W_CLR
  } wdat_sel_t;

  // Branch condition.
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_START,
    C_IS_FREE,
    C_H_END,
    C_HIT,
    C_SPLIT,
    C_SPLIT_IN,
    C_BAD_OR_CLEAR
  } cond_t;

  // Result emitted by a step.
  typedef enum logic [1:0] {
    E_NONE,
    E_FAIL,
    E_ALLOC,
    E_FREED
  } emit_t;

  // One control word.
  typedef struct packed {
    mem_op_t   mem;
    addr_sel_t asel;
    wdat_sel_t wsel;
    cond_t     cond;
    step_t     t_true;
    step_t     t_false;
    logic      h_adv;
    emit_t     emit;
  } uop_t;

  // Control store: one control word per step.
  function automatic uop_t ucode(step_t s);
    uop_t u;
    u = '{mem: M_NONE, asel: A_ZERO, wsel: W_INIT, cond: C_ALWAYS,
          t_true: S_IDLE, t_false: S_IDLE, h_adv: 1'b0, emit: E_NONE};
    case (s)
      // Write the single free block that spans the heap.
      S_INIT: begin
        u.mem = M_WR;
        u.asel = A_ZERO;
        u.wsel = W_INIT;
      end
      S_IDLE: begin
        u.cond = C_START;
        u.t_true = S_DISPATCH;
        u.t_false = S_IDLE;
      end
      S_DISPATCH: begin
        u.cond = C_IS_FREE;
        u.t_true = S_F_CHK;
        u.t_false = S_A_RD;
      end
      // Fetch the header at the walk pointer, or fail past the heap end.
      S_A_RD: begin
        u.mem = M_RD;
        u.asel = A_HDR;
        u.cond = C_H_END;
        u.t_true = S_FAIL;
        u.t_false = S_A_WAIT;
      end
      // Test the header; on a miss the pointer steps to the next block.
      S_A_WAIT: begin
        u.cond = C_HIT;
        u.t_true = S_A_HIT;
        u.t_false = S_A_RD;
        u.h_adv = 1'b1;
      end
      S_A_HIT: begin
        u.cond = C_SPLIT;
        u.t_true = S_A_SPLIT;
        u.t_false = S_A_TAKE;
      end
      S_A_TAKE: begin
        u.mem = M_WR;
        u.asel = A_HDR;
        u.wsel = W_TAKE;
        u.emit = E_ALLOC;
      end
      S_A_SPLIT: begin
        u.cond = C_SPLIT_IN;
        u.t_true = S_A_WREST;
        u.t_false = S_A_WHDR;
      end
      S_A_WREST: begin
        u.mem = M_WR;
        u.asel = A_SPLIT;
        u.wsel = W_REST;
        u.t_true = S_A_WHDR;
      end
      S_A_WHDR: begin
        u.mem = M_WR;
        u.asel = A_HDR;
        u.wsel = W_RND;
        u.emit = E_ALLOC;
      end
      // Fetch the header in front of the payload, or fail on a bad index.
      S_F_CHK: begin
        u.mem = M_RD;
        u.asel = A_FREE;
        u.cond = C_BAD_OR_CLEAR;
        u.t_true = S_FAIL;
        u.t_false = S_F_WAIT;
      end
      S_F_WAIT: begin
        u.cond = C_BAD_OR_CLEAR;
        u.t_true = S_FAIL;
        u.t_false = S_F_CLR;
      end
      S_F_CLR: begin
        u.mem = M_WR;
        u.asel = A_FREE;
        u.wsel = W_CLR;
        u.emit = E_FREED;
      end
      S_FAIL: begin
        u.emit = E_FAIL;
      end
      default: begin
        u.t_true = S_IDLE;
      end
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

// File: src/first_fit_heap_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core: first-fit allocator over an implicit list.
// A microcoded sequencer walks block headers held in an on-chip memory.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low. Each command
// gives exactly one result word, shown for one cycle with done high; the
// receiver cannot stall it. Busy stays high through the last step of a
// command; done shows its result in the cycle after, and in that cycle the
// next command may already be taken. An allocate walks the header chain from
// word 0 and visits each header with one registered read of the header memory
// and one test. A free reads the header in front of the payload and clears its
// used bit; it fails when the payload index is zero or past the heap, or when
// that block is not in use. After reset the sequencer writes the initial free
// header, with busy high.
`default_nettype none

module first_fit_heap_allocator_core #(
  parameter int HEAP_BYTES = ffha_pkg::HEAP_BYTES_DEF
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               start,
  output logic              busy,
  input  ffha_pkg::cmd_t    cmd,
  output logic              done,
  output ffha_pkg::result_t result
);

  import ffha_pkg::*;

  // Heap geometry derived from the heap size.
  localparam int WORDS = HEAP_BYTES / WORD_BYTES;
  localparam int AW    = $clog2(WORDS);
  localparam int HW    = $clog2(HEAP_BYTES);
  localparam int CW    = ((HW > SIZE_W) ? HW : SIZE_W) + 2;
  localparam int PW    = ((AW + 1) > INDEX_W) ? (AW + 1) : INDEX_W;
  localparam logic [HW-1:0] INIT_HDR = HW'(HEAP_BYTES - WORD_BYTES);

  // Sequencer and datapath registers.
  step_t          upc;
  step_t          upc_next;
  logic [AW:0]    h;
  logic [CW-1:0]  req;
  logic [CW-1:0]  req_rnd;
  logic [CW-1:0]  req_lim;
  logic [PW-1:0]  fidx;
  logic           fzero;
  logic           op_free;
  logic [HW-1:0]  rd_data;
  logic [HW-1:0]  mem [WORDS];

  uop_t           uop;
  logic           accept;
  logic           cond_true;
  logic [CW-1:0]  blk;
  logic           hit;
  logic           split_ok;
  logic [CW-1:0]  split_w;
  logic           split_in;
  logic           free_bad;
  logic [AW:0]    h_next;
  logic [AW-1:0]  addr;
  logic [HW-1:0]  wdata;
  logic [PW-1:0]  alloc_idx;
  logic [CW-1:0]  rest;
  logic [CW-1:0]  cmd_size;

  assign uop    = ucode(upc);
  assign busy   = (upc != S_IDLE);
  assign accept = start && !busy;

  // Header decode and the tests the microcode branches on.
  assign blk       = CW'({rd_data[HW-1:1], 1'b0});
  assign hit       = !rd_data[0] && (blk >= req);
  assign split_ok  = (blk >= req_lim);
  assign split_w   = CW'(h) + CW'(1) + (req_rnd >> 3);
  assign split_in  = (split_w < CW'(WORDS));
  assign free_bad  = fzero || (fidx >= PW'(WORDS));
  assign h_next    = h + (AW + 1)'(rd_data[HW-1:3]) + (AW + 1)'(1);
  assign alloc_idx = PW'(h) + PW'(1);
  assign rest      = blk - req_rnd - CW'(WORD_BYTES);
  assign cmd_size  = CW'(cmd.size_bytes);

  always_comb begin
    case (uop.cond)
      C_ALWAYS:       cond_true = 1'b1;
      C_START:        cond_true = start;
      C_IS_FREE:      cond_true = op_free;
      C_H_END:        cond_true = (h >= (AW + 1)'(WORDS));
      C_HIT:          cond_true = hit;
      C_SPLIT:        cond_true = split_ok;
      C_SPLIT_IN:     cond_true = split_in;
      C_BAD_OR_CLEAR: cond_true = free_bad || ((upc == S_F_WAIT) && !rd_data[0]);
      default:        cond_true = 1'b1;
    endcase
  end

  // Memory address and write data selection.
  always_comb begin
    case (uop.asel)
      A_ZERO:  addr = '0;
      A_HDR:   addr = h[AW-1:0];
      A_SPLIT: addr = split_w[AW-1:0];
      A_FREE:  addr = fidx[AW-1:0];
      default: addr = '0;
    endcase
  end

  always_comb begin
    case (uop.wsel)
      W_INIT:  wdata = INIT_HDR;
      W_TAKE:  wdata = rd_data | HW'(1);
      W_RND:   wdata = req_rnd[HW-1:0] | HW'(1);
      W_REST:  wdata = rest[HW-1:0];
      W_CLR:   wdata = {rd_data[HW-1:1], 1'b0};
      default: wdata = rd_data;
    endcase
  end

  // Next step: the branch condition picks one of the two targets.
  always_comb begin
    upc_next = cond_true ? uop.t_true : uop.t_false;
  end

  // Header memory: one port, registered read data.
  always_ff @(posedge clk) begin
    if (uop.mem == M_WR) begin
      mem[addr] <= wdata;
    end
    if (uop.mem == M_RD) begin
      rd_data <= mem[addr];
    end
  end

  // Step counter and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      upc  <= S_INIT;
      done <= 1'b0;
    end else begin
      upc  <= upc_next;
      done <= (uop.emit != E_NONE);
    end
  end

  // Command latch, walk pointer and result word.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_free <= (cmd.opcode == OP_FREE);
      req     <= cmd_size;
      req_rnd <= (cmd_size + CW'(ALIGN_BYTES - 1)) & ~CW'(ALIGN_BYTES - 1);
      req_lim <= cmd_size + CW'(ALIGN_BYTES);
      fidx    <= PW'(cmd.payload_index) - PW'(1);
      fzero   <= (cmd.payload_index == '0);
      h       <= '0;
    end else if (uop.h_adv && !cond_true) begin
      h <= h_next;
    end
    case (uop.emit)
      E_FAIL:  result <= '{ok: 1'b0, result_index: '0};
      E_ALLOC: result <= '{ok: 1'b1, result_index: alloc_idx[INDEX_W-1:0]};
      E_FREED: result <= '{ok: 1'b1, result_index: '0};
      default: result <= result;
    endcase
  end

endmodule

`default_nettype wire
